[sv/mig_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mig_pkg: shared constants and arithmetic for the matrix inverter
// Q16.16 format constants and saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package mig_pkg;

    localparam int unsigned MaxOrderDefault = 8;
    localparam int unsigned SizeW           = 4;
    localparam int unsigned DataW           = 32;
    localparam logic [3:0]  SizeReset       = 4'd3;
    localparam logic signed [31:0] OneQ     = 32'sh0001_0000;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // status between sequencer and arithmetic unit
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage
`default_nettype wire

[sv/mig_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mig_div: Q16.16 divider
// Restoring radix-2 divider of |x|*2^16 by |y|, one quotient bit a cycle,
// rounded to nearest with ties away from zero and saturated.
// ----------------------------------------------------------------------------
module mig_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [31:0]   i_x,
    input  wire signed [31:0]   i_y,
    output logic                o_done,
    output logic signed [31:0]  o_q
);
    import mig_pkg::*;

    localparam int unsigned NumW = 49;

    logic [NumW-1:0] r_num;
    logic [NumW-1:0] r_quo;
    logic [33:0]     r_rem;
    logic [32:0]     r_den;
    logic            r_neg;
    logic [5:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic signed [31:0] r_q;

    logic [33:0] w_trial;
    logic [33:0] w_shift;
    logic [NumW:0] w_rnd;
    logic [32:0] w_ax;

    assign w_ax    = i_x[31] ? (33'd0 - {i_x[31], i_x}) : {1'b0, i_x};
    assign w_shift = {r_rem[32:0], r_num[NumW-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    // round: remainder*2 >= den means round up
    assign w_rnd   = {1'b0, r_quo} + (({r_rem, 1'b0} >= {2'b0, r_den}) ? 1'b1 : 1'b0);

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NumW);
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_ax[32:0], 16'd0};
            r_den <= i_y[31] ? (33'd0 - {i_y[31], i_y}) : {1'b0, i_y};
            r_neg <= i_x[31] ^ i_y[31];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_num <= {r_num[NumW-2:0], 1'b0};
            if (!w_trial[33]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[NumW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[NumW-2:0], 1'b0};
            end
        end else if (r_busy) begin
            r_q <= sat32(r_neg ? -$signed({16'd0, w_rnd}) : $signed({16'd0, w_rnd}));
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

    property p_done_once;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done;
    endproperty
    a_done_once: assert property (p_done_once) else $error("divider done held");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

    property p_no_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy && !i_start |=> r_busy || o_done;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("divider lost");

endmodule
`default_nettype wire

[sv/mig_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mig_mul: Q16.16 multiplier
// Registered 32x32 product, then rounding to nearest (ties away) and
// saturation in a second stage.
// ----------------------------------------------------------------------------
module mig_mul (
    input  wire                 i_clk,
    input  wire signed [31:0]   i_a,
    input  wire signed [31:0]   i_b,
    output logic signed [31:0]  o_p
);
    import mig_pkg::*;

    logic signed [63:0] r_prod;
    logic [63:0]        w_mag;
    logic [48:0]        w_r;

    // stage one: raw product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign w_mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;
    assign w_r   = 49'((w_mag + 64'd32768) >> 16);

    // stage two: round and saturate
    always_ff @(posedge i_clk) begin
        o_p <= sat32(r_prod[63] ? -$signed({17'd0, w_r}) : $signed({17'd0, w_r}));
    end

endmodule
`default_nettype wire

[sv/matrix_inverse_gauss_jordan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan: Gauss-Jordan inverter, Q16.16
// Loads A row-major into an augmented store, eliminates forward and
// backward, scales rows, then streams out the inverse or a singular flag word.
// ----------------------------------------------------------------------------
// channel   dir  word                         handshake
// s_axis    in   tdata[31:0] element_value    tvalid/tready
// m_axis    out  tdata[31:0] inverse_value    tvalid/tready, tlast, tuser
// cfg       in   matrix_size                  i_cfg_we
//
// an item is taken per cycle while loading; after the last element the block
// runs elimination through the store's one read and one write port: each
// multiply-subtract step takes two reads, the 2-stage multiplier and a
// write, and each pivot quotient takes the serial divider. input stalls
// during compute and output.
// reset is synchronous; the store holds no reset value.
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan #(
    parameter int unsigned MAX_ORDER = mig_pkg::MaxOrderDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [3:0]   i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // [31:0] element_value
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] inverse_value
    output logic        m_axis_tuser,   // [0] singular
    output logic        m_axis_tlast
);
    import mig_pkg::*;

    localparam int unsigned RW    = $clog2(MAX_ORDER);
    localparam int unsigned CW    = RW + 1;
    localparam int unsigned AW    = RW + CW;
    localparam int unsigned Depth = 2 * MAX_ORDER * MAX_ORDER;

    localparam logic [4:0] S_LOAD = 5'd0,  S_INIT = 5'd1,  S_PIV = 5'd2,
        S_PIVW = 5'd3, S_SRCH = 5'd4, S_SRCHW = 5'd5, S_SWR = 5'd6,
        S_SWW = 5'd7, S_SWW2 = 5'd8, S_FRD = 5'd9, S_FRW = 5'd10,
        S_DIV = 5'd11, S_ERD = 5'd12, S_EW1 = 5'd13, S_EMUL = 5'd14,
        S_EWB = 5'd15, S_NEXT = 5'd16, S_SCD = 5'd17, S_SCDW = 5'd18,
        S_OUT = 5'd19, S_OUTW = 5'd20, S_SING = 5'd21, S_ELAT = 5'd22,
        S_SWR2 = 5'd23;

    // store
    logic signed [31:0] r_mem [Depth];
    logic signed [31:0] r_rd;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic               w_we;
    logic signed [31:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    logic [3:0]    r_size;
    logic [RW:0]   w_n;
    logic [4:0]    r_st;
    logic [RW:0]   r_li, r_lj;
    logic [RW:0]   r_k, r_i, r_s;
    logic [CW:0]   r_j;
    logic          r_back;
    logic [RW:0]   w_w;
    logic signed [31:0] r_piv, r_f, r_t, r_oq;
    logic          r_ovalid, r_olast, r_osing;

    assign w_n = (r_size == 4'd0) ? (RW+1)'(1)
               : ({1'b0, r_size} > 5'(MAX_ORDER)) ? (RW+1)'(MAX_ORDER)
               : (RW+1)'(r_size);
    assign w_w = w_n;

    function automatic logic [AW-1:0] adr(input logic [RW:0] r, input logic [CW:0] c);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    // arithmetic units
    t_div_ctl w_dc;
    logic signed [31:0] w_dx, w_dy, w_q, w_p, w_ma;
    logic w_done;
    assign w_dc.start = (r_st == S_FRW) || (r_st == S_SCDW);
    assign w_dc.busy  = 1'b0;
    assign w_dx = (r_st == S_SCDW) ? OneQ : r_rd;
    // the diagonal for scaling is still on the read port
    assign w_dy = (r_st == S_SCDW) ? r_rd : r_piv;
    mig_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dc.start),
        .i_x(w_dx), .i_y(w_dy), .o_done(w_done), .o_q(w_q));
    assign w_ma = r_back ? r_rd : r_f;
    mig_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(r_back ? r_f : r_rd), .o_p(w_p));

    logic [1:0] r_mc;
    logic       r_scale;

    // read and write addressing
    always_comb begin
        w_raddr = adr(r_k, r_j);
        w_we    = 1'b0;
        w_waddr = adr(r_i, r_j);
        w_wdata = r_t;
        case (r_st)
            S_LOAD: begin
                w_we    = s_axis_tvalid && s_axis_tready;
                w_waddr = adr(r_li, (CW+1)'(r_lj));
                w_wdata = s_axis_tdata;
            end
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = adr(r_i, r_j);
                w_wdata = ((r_j - (CW+1)'(w_n)) == (CW+1)'(r_i)) ? OneQ : 32'sd0;
            end
            S_PIV:   w_raddr = adr(r_k, (CW+1)'(r_k));
            S_SRCH:  w_raddr = adr(r_s, (CW+1)'(r_k));
            S_SWR:   w_raddr = adr(r_k, r_j);
            S_SWR2:  w_raddr = adr(r_s, r_j);
            S_SWW: begin
                // keep the old row s word on the read port
                w_raddr = adr(r_s, r_j);
                w_we = 1'b1; w_waddr = adr(r_s, r_j); w_wdata = r_t;
            end
            S_SWW2: begin
                w_we = 1'b1; w_waddr = adr(r_k, r_j); w_wdata = r_rd;
            end
            S_FRD:   w_raddr = adr(r_i, (CW+1)'(r_k));
            // target word first, then the multiplier operand
            S_ERD:   w_raddr = adr(r_i, r_j);
            S_EW1:   w_raddr = r_scale ? adr(r_i, r_j) : adr(r_k, r_j);
            S_EWB: begin
                w_we = 1'b1; w_waddr = adr(r_i, r_j);
                w_wdata = r_scale ? w_p
                        : sat32(66'(r_t) - 66'(w_p));
            end
            S_SCD:   w_raddr = adr(r_i, (CW+1)'(r_i));
            S_OUT:   w_raddr = adr(r_i, r_j + (CW+1)'(w_n));
            default: ;
        endcase
    end

    logic w_take;
    assign s_axis_tready = (r_st == S_LOAD);
    assign w_take = s_axis_tvalid && s_axis_tready;
    logic w_ofree;
    assign w_ofree = !r_ovalid || m_axis_tready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_size <= SizeReset; r_li <= '0; r_lj <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata; r_li <= '0; r_lj <= '0;
            end
            case (r_st)
                S_LOAD: if (w_take && !i_cfg_we) begin
                    if (r_lj == w_n - 1'b1) begin
                        r_lj <= '0;
                        if (r_li == w_n - 1'b1) begin
                            r_li <= '0; r_st <= S_INIT;
                            r_i <= '0; r_j <= (CW+1)'(w_n);
                        end else r_li <= r_li + 1'b1;
                    end else r_lj <= r_lj + 1'b1;
                end
                S_INIT: begin
                    if (r_j == (CW+1)'(2*w_w) - 1'b1) begin
                        r_j <= (CW+1)'(w_n);
                        if (r_i == w_n - 1'b1) begin
                            r_k <= '0; r_back <= 1'b0; r_scale <= 1'b0;
                            r_st <= (w_n == 1) ? S_SCD : S_PIV;
                            r_i <= '0;
                        end else r_i <= r_i + 1'b1;
                    end else r_j <= r_j + 1'b1;
                end
                S_PIV:  r_st <= S_PIVW;
                S_PIVW: begin
                    r_piv <= r_rd; r_s <= r_k + 1'b1;
                    r_i <= r_back ? '0 : r_k + 1'b1;
                    r_st <= (r_rd != 0) ? S_FRD : (r_k == w_n - 1'b1) ? S_SING : S_SRCH;
                end
                S_SRCH:  r_st <= S_SRCHW;
                S_SRCHW: begin
                    if (r_rd != 0) begin
                        r_piv <= r_rd; r_j <= '0; r_st <= S_SWR;
                    end else if (r_s == w_n - 1'b1) r_st <= S_SING;
                    else begin
                        r_s <= r_s + 1'b1; r_st <= S_SRCH;
                    end
                end
                S_SWR:  r_st <= S_SWR2;
                S_SWR2: begin r_t <= r_rd; r_st <= S_SWW; end
                S_SWW:  r_st <= S_SWW2;
                S_SWW2: begin
                    if (r_j == (CW+1)'(2*w_w) - 1'b1) begin
                        r_st <= S_FRD; r_i <= r_back ? '0 : r_k + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1; r_st <= S_SWR;
                    end
                end
                S_FRD:  r_st <= S_FRW;
                S_FRW:  r_st <= S_DIV;
                S_DIV:  if (w_done) begin
                    r_f <= w_q; r_j <= '0; r_st <= S_ERD;
                end
                S_ERD:  r_st <= S_EW1;
                S_EW1:  begin r_t <= r_rd; r_mc <= '0; r_st <= S_EMUL; end
                S_EMUL: begin
                    if (r_mc == 2'd0) r_st <= S_ELAT;
                end
                S_ELAT: r_st <= S_EWB;
                S_EWB: begin
                    if (r_j == (CW+1)'(2*w_w) - 1'b1) r_st <= S_NEXT;
                    else begin
                        r_j <= r_j + 1'b1; r_st <= S_ERD;
                    end
                end
                S_NEXT: begin
                    if (r_scale) begin
                        if (r_i == w_n - 1'b1) begin
                            r_i <= '0; r_j <= '0; r_st <= S_OUT;
                        end else begin
                            r_i <= r_i + 1'b1; r_st <= S_SCD;
                        end
                    end else if (!r_back) begin
                        if (r_i == w_n - 1'b1) begin
                            if (r_k == w_n - 2) begin
                                r_back <= 1'b1; r_k <= w_n - 1'b1; r_st <= S_PIV;
                            end else begin
                                r_k <= r_k + 1'b1; r_st <= S_PIV;
                            end
                        end else begin
                            r_i <= r_i + 1'b1; r_st <= S_FRD;
                        end
                    end else begin
                        if (r_i == r_k - 1'b1) begin
                            if (r_k == 1) begin
                                r_scale <= 1'b1; r_back <= 1'b0;
                                r_i <= '0; r_st <= S_SCD;
                            end else begin
                                r_k <= r_k - 1'b1; r_st <= S_PIV;
                            end
                        end else begin
                            r_i <= r_i + 1'b1; r_st <= S_FRD;
                        end
                    end
                end
                S_SCD:  r_st <= S_SCDW;
                S_SCDW: begin
                    r_scale <= 1'b1;
                    r_piv <= r_rd;
                    if (r_rd == 0) r_st <= S_SING;
                    else if (r_rd == OneQ) r_st <= S_NEXT;
                    else r_st <= S_DIV;
                end
                S_OUT: if (w_ofree) r_st <= S_OUTW;
                S_OUTW: begin
                    r_ovalid <= 1'b1; r_oq <= r_rd; r_osing <= 1'b0;
                    r_olast <= (r_i == w_n - 1'b1) && (r_j == (CW+1)'(w_n) - 1'b1);
                    if (r_j == (CW+1)'(w_n) - 1'b1) begin
                        r_j <= '0;
                        if (r_i == w_n - 1'b1) r_st <= S_LOAD;
                        else begin r_i <= r_i + 1'b1; r_st <= S_OUT; end
                    end else begin
                        r_j <= r_j + 1'b1; r_st <= S_OUT;
                    end
                end
                // wait for an empty output register
                S_SING: if (!r_ovalid) begin
                    r_ovalid <= 1'b1; r_oq <= '0; r_osing <= 1'b1; r_olast <= 1'b1;
                    r_st <= S_LOAD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oq;
    assign m_axis_tuser  = r_osing;
    assign m_axis_tlast  = r_olast;

    property p_sing_last;
        @(posedge i_clk) disable iff (!i_rst_n) m_axis_tvalid && m_axis_tuser |-> m_axis_tlast;
    endproperty
    a_sing_last: assert property (p_sing_last) else $error("singular word not last");

    property p_no_load_busy;
        @(posedge i_clk) disable iff (!i_rst_n) s_axis_tready |-> r_st == S_LOAD;
    endproperty
    a_no_load_busy: assert property (p_no_load_busy) else $error("ready while busy");

    property p_sing_zero;
        @(posedge i_clk) disable iff (!i_rst_n) m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 0;
    endproperty
    a_sing_zero: assert property (p_sing_zero) else $error("singular data nonzero");

endmodule
`default_nettype wire
